// File: rtl/ssmbc_pkg.sv
// shared types and constants of the stereo mixer with bias and clamp
`default_nettype none

package ssmbc_pkg;

  // register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_MIX_CTRL    = 2'd0,
    REG_DIRECT_CTRL = 2'd1,
    REG_MASTER_EN   = 2'd2,
    REG_BIAS_LEVEL  = 2'd3
  } cfg_reg_e;

  // tone volume shift codes, direct_control bits 1:0
  typedef enum logic [1:0] {
    SHIFT_QUARTER    = 2'd0,
    SHIFT_HALF       = 2'd1,
    SHIFT_FULL       = 2'd2,
    SHIFT_PROHIBITED = 2'd3
  } vol_shift_e;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned BIAS_W     = 10;

  // floor(m / 7) == (m * 2341) >> 14 for every m below 2689
  localparam logic [11:0] RECIP_7       = 12'd2341;
  localparam int unsigned RECIP_7_SHIFT = 14;

  localparam logic [9:0] CLAMP_MAX = 10'h3FF;

  typedef struct packed {
    logic signed [7:0] tone1_sample;
    logic signed [7:0] tone2_sample;
    logic signed [7:0] noise_sample;
    logic signed [7:0] direct_a_sample;
    logic signed [7:0] direct_b_sample;
  } mix_in_t;

  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic               bad_volume;
  } mix_out_t;

endpackage

`default_nettype wire

// File: rtl/stereo_sound_mixer_bias_clamp_unit.sv
// stereo mixer: per-side gating, volume, bias, ten-bit clamp and re-centering
//
// Input channel (in_valid_i / in_ready_o / in_data_i) carries one beat per
// sound tick: three tone/noise samples and two direct samples. Output channel
// (out_valid_o / out_ready_i / out_data_o) returns one beat per input beat,
// in order, with the left and right samples and the prohibited-volume flag.
// The path is four register stages: gating and direct scaling, tone volume
// multiply, divide by seven through a reciprocal multiply, then the shift,
// bias add and clamp into the output register, whose valid bit is
// out_valid_o. One beat is taken every cycle while the receiver
// keeps out_ready_i high. When the receiver stalls, each stage holds its beat
// and bubbles collapse, so input is still taken until all four stages fill.
// The configuration port writes one register per cycle with cfg_we_i; write
// only while the pipeline is empty. Reset clears the configuration registers
// to zero and empties the pipeline; with master enable off both sides carry
// only the clamped bias.
`default_nettype none

module stereo_sound_mixer_bias_clamp_unit (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_we_i,
  input  wire logic [ssmbc_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [ssmbc_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  wire logic                                   in_valid_i,
  output      logic                                   in_ready_o,
  input  wire ssmbc_pkg::mix_in_t                     in_data_i,
  output      logic                                   out_valid_o,
  input  wire logic                                   out_ready_i,
  output      ssmbc_pkg::mix_out_t                    out_data_o
);

  localparam int unsigned LEFT  = 0;
  localparam int unsigned RIGHT = 1;

  // configuration registers
  logic [15:0]                      mix_ctrl_q;
  logic [15:0]                      dir_ctrl_q;
  logic                             master_en_q;
  logic [ssmbc_pkg::BIAS_W-1:0]     bias_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_ctrl_q  <= '0;
      dir_ctrl_q  <= '0;
      master_en_q <= 1'b0;
      bias_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (ssmbc_pkg::cfg_reg_e'(cfg_idx_i))
        ssmbc_pkg::REG_MIX_CTRL:    mix_ctrl_q  <= cfg_wdata_i;
        ssmbc_pkg::REG_DIRECT_CTRL: dir_ctrl_q  <= cfg_wdata_i;
        ssmbc_pkg::REG_MASTER_EN:   master_en_q <= cfg_wdata_i[0];
        ssmbc_pkg::REG_BIAS_LEVEL:  bias_q      <= cfg_wdata_i[ssmbc_pkg::BIAS_W-1:0];
        default:                    mix_ctrl_q  <= mix_ctrl_q;
      endcase
    end
  end

  ssmbc_pkg::vol_shift_e shift_code;
  assign shift_code = ssmbc_pkg::vol_shift_e'(dir_ctrl_q[1:0]);

  // stage valid bits and bubble-collapsing readies
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4       = !v4_q || out_ready_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // halve toward zero
  function automatic logic signed [7:0] half_trunc(input logic signed [7:0] x);
    logic signed [8:0] t;
    t = {x[7], x} + {8'b0, x[7]};
    return t[8:1];
  endfunction

  // ---------------- stage 1: gating, tone sum, direct terms
  logic signed [9:0]  tone_d [2];
  logic signed [10:0] dir_d  [2];
  logic        [2:0]  vol_d  [2];
  logic               bad_d;

  logic signed [9:0]  tone1_q [2];
  logic signed [10:0] dir1_q  [2];
  logic        [2:0]  vol1_q  [2];
  logic               bad1_q;

  always_comb begin
    logic [2:0]        vol [2];
    logic              en_t1 [2];
    logic              en_t2 [2];
    logic              en_nz [2];
    logic              en_a  [2];
    logic              en_b  [2];
    logic signed [7:0] a_w;
    logic signed [7:0] b_w;
    logic signed [8:0] ab_w;

    vol[LEFT]    = mix_ctrl_q[6:4];
    en_t1[LEFT]  = mix_ctrl_q[12];
    en_t2[LEFT]  = mix_ctrl_q[13];
    en_nz[LEFT]  = mix_ctrl_q[15];
    en_a[LEFT]   = dir_ctrl_q[9];
    en_b[LEFT]   = dir_ctrl_q[13];
    vol[RIGHT]   = mix_ctrl_q[2:0];
    en_t1[RIGHT] = mix_ctrl_q[8];
    en_t2[RIGHT] = mix_ctrl_q[9];
    en_nz[RIGHT] = mix_ctrl_q[11];
    en_a[RIGHT]  = dir_ctrl_q[8];
    en_b[RIGHT]  = dir_ctrl_q[12];

    for (int s = 0; s < 2; s++) begin
      tone_d[s] = '0;
      if (master_en_q && en_t1[s]) begin
        tone_d[s] = tone_d[s] + {{2{in_data_i.tone1_sample[7]}}, in_data_i.tone1_sample};
      end
      if (master_en_q && en_t2[s]) begin
        tone_d[s] = tone_d[s] + {{2{in_data_i.tone2_sample[7]}}, in_data_i.tone2_sample};
      end
      if (master_en_q && en_nz[s]) begin
        tone_d[s] = tone_d[s] + {{2{in_data_i.noise_sample[7]}}, in_data_i.noise_sample};
      end
      a_w = (master_en_q && en_a[s]) ? in_data_i.direct_a_sample : 8'sd0;
      b_w = (master_en_q && en_b[s]) ? in_data_i.direct_b_sample : 8'sd0;
      if (!dir_ctrl_q[2]) a_w = half_trunc(a_w);
      if (!dir_ctrl_q[3]) b_w = half_trunc(b_w);
      ab_w     = {a_w[7], a_w} + {b_w[7], b_w};
      dir_d[s] = {ab_w, 2'b00};
      vol_d[s] = vol[s];
    end
    bad_d = master_en_q && (shift_code == ssmbc_pkg::SHIFT_PROHIBITED);
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      tone1_q <= tone_d;
      dir1_q  <= dir_d;
      vol1_q  <= vol_d;
      bad1_q  <= bad_d;
    end
  end

  // ---------------- stage 2: magnitude times volume
  logic [11:0]        prod2_q [2];
  logic               neg2_q  [2];
  logic signed [10:0] dir2_q  [2];
  logic               bad2_q;

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      for (int s = 0; s < 2; s++) begin
        logic [9:0] mag;
        mag        = tone1_q[s][9] ? (10'd0 - tone1_q[s]) : tone1_q[s];
        prod2_q[s] <= 12'(mag[8:0]) * 12'(vol1_q[s]);
        neg2_q[s]  <= tone1_q[s][9];
      end
      dir2_q <= dir1_q;
      bad2_q <= bad1_q;
    end
  end

  // ---------------- stage 3: divide by seven via reciprocal
  logic [8:0]         quo3_q [2];
  logic               neg3_q [2];
  logic signed [10:0] dir3_q [2];
  logic               bad3_q;

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      for (int s = 0; s < 2; s++) begin
        logic [23:0] recip_prod;
        recip_prod = 24'(prod2_q[s]) * 24'(ssmbc_pkg::RECIP_7);
        quo3_q[s] <= recip_prod[ssmbc_pkg::RECIP_7_SHIFT +: 9];
        neg3_q[s] <= neg2_q[s];
      end
      dir3_q <= dir2_q;
      bad3_q <= bad2_q;
    end
  end

  // ---------------- stage 4: volume shift, sum with direct terms and bias, clamp, re-center
  logic [15:0] side_d [2];

  always_comb begin
    logic [8:0]         shifted;
    logic signed [9:0]  tone_s;
    logic signed [12:0] total;
    logic [9:0]         clamped;
    for (int s = 0; s < 2; s++) begin
      unique case (shift_code)
        ssmbc_pkg::SHIFT_QUARTER:    shifted = quo3_q[s] >> 2;
        ssmbc_pkg::SHIFT_HALF:       shifted = quo3_q[s] >> 1;
        ssmbc_pkg::SHIFT_FULL:       shifted = quo3_q[s];
        ssmbc_pkg::SHIFT_PROHIBITED: shifted = quo3_q[s];
        default:                     shifted = quo3_q[s];
      endcase
      tone_s = neg3_q[s] ? (10'sd0 - {1'b0, shifted}) : {1'b0, shifted};
      total  = {{2{dir3_q[s][10]}}, dir3_q[s]} + {{3{tone_s[9]}}, tone_s}
             + {3'b000, bias_q};
      priority if (total[12]) begin
        clamped = '0;
      end else if (total[11:10] != 2'b00) begin
        clamped = ssmbc_pkg::CLAMP_MAX;
      end else begin
        clamped = total[9:0];
      end
      // minus 512 in ten bits is a flip of the top bit
      side_d[s] = {~clamped[9], clamped[8:0], 6'b000000};
    end
  end

  ssmbc_pkg::mix_out_t out_q;

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      out_q.left_sample  <= side_d[LEFT];
      out_q.right_sample <= side_d[RIGHT];
      out_q.bad_volume   <= bad3_q;
    end
  end

  assign out_valid_o = v4_q;
  assign out_data_o  = out_q;

  // ---------------- assertions
  a_bad_needs_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bad_volume |->
      master_en_q && shift_code == ssmbc_pkg::SHIFT_PROHIBITED)
    else $error("bad_volume without master enable and prohibited code");

  a_master_off_bias_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !master_en_q |->
      out_data_o.left_sample == out_data_o.right_sample && !out_data_o.bad_volume)
    else $error("sides differ with master enable off");

  a_low_bits_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      out_data_o.left_sample[5:0] == 6'd0 && out_data_o.right_sample[5:0] == 6'd0)
    else $error("low six bits of a mixed sample not zero");

  a_stall_holds_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && v2_q && v3_q && v4_q && !out_ready_i |=> v1_q && v4_q)
    else $error("full pipeline lost a beat under stall");

endmodule

`default_nettype wire

// File: tb/stereo_sound_mixer_bias_clamp_unit_tb.sv
// self-checking testbench for the stereo mixer with bias, clamp and re-centering
`default_nettype none

module stereo_sound_mixer_bias_clamp_unit_tb;

  localparam int QUIET_LIMIT = 1000;
  localparam int HOLD_LEN    = 60;
  localparam int DRAIN_TAIL  = 8;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             cfg_we_i = 1'b0;
  logic [ssmbc_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [ssmbc_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                             in_valid_i = 1'b0;
  logic                             in_ready_o;
  ssmbc_pkg::mix_in_t               in_data_i = '0;
  logic                             out_valid_o;
  logic                             out_ready_i = 1'b0;
  ssmbc_pkg::mix_out_t              out_data_o;

  stereo_sound_mixer_bias_clamp_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // register copies
  logic [15:0] mix_ctrl = '0;
  logic [15:0] direct_ctrl = '0;
  logic        master_en = 1'b0;
  logic [9:0]  bias_lvl = '0;

  ssmbc_pkg::mix_out_t pending_mix[$];
  ssmbc_pkg::mix_out_t want;
  int       errors = 0;
  int       beats_sent = 0;
  int       beats_checked = 0;
  int       settings_used = 0;
  int       snd_idle_pct = 0;
  int       rcv_idle_pct = 0;
  int       hold_asked = 0;
  int       hold_served = 0;
  int       hold_left = 0;
  int       quiet_cycles = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // one side of the mix; en is {noise, tone2, tone1}
  function automatic logic signed [15:0] side_level(logic [2:0] vol, logic [2:0] en,
                                                    logic a_on, logic b_on,
                                                    ssmbc_pkg::mix_in_t t);
    int tone;
    int a;
    int b;
    int acc;
    acc = 0;
    if (master_en) begin
      tone = 0;
      if (en[0]) tone += int'(t.tone1_sample);
      if (en[1]) tone += int'(t.tone2_sample);
      if (en[2]) tone += int'(t.noise_sample);
      tone = (tone * int'(vol)) / 7;
      case (ssmbc_pkg::vol_shift_e'(direct_ctrl[1:0]))
        ssmbc_pkg::SHIFT_QUARTER: tone = tone / 4;
        ssmbc_pkg::SHIFT_HALF:    tone = tone / 2;
        default:                  ;
      endcase
      a = a_on ? int'(t.direct_a_sample) : 0;
      b = b_on ? int'(t.direct_b_sample) : 0;
      if (!direct_ctrl[2]) a = a / 2;
      if (!direct_ctrl[3]) b = b / 2;
      acc = (a + b) * 4 + tone;
    end
    acc += int'(bias_lvl);
    if (acc < 0) acc = 0;
    else if (acc > int'(ssmbc_pkg::CLAMP_MAX)) acc = int'(ssmbc_pkg::CLAMP_MAX);
    acc = (acc - 512) * 64;
    return 16'(acc);
  endfunction

  function automatic ssmbc_pkg::mix_out_t mix_tick(ssmbc_pkg::mix_in_t t);
    ssmbc_pkg::mix_out_t r;
    r.left_sample  = side_level(mix_ctrl[6:4], {mix_ctrl[15], mix_ctrl[13], mix_ctrl[12]},
                                direct_ctrl[9], direct_ctrl[13], t);
    r.right_sample = side_level(mix_ctrl[2:0], {mix_ctrl[11], mix_ctrl[9], mix_ctrl[8]},
                                direct_ctrl[8], direct_ctrl[12], t);
    r.bad_volume   = master_en && (direct_ctrl[1:0] == ssmbc_pkg::SHIFT_PROHIBITED);
    return r;
  endfunction

  function automatic ssmbc_pkg::mix_in_t make_tick(int t1, int t2, int nz, int a, int b);
    ssmbc_pkg::mix_in_t t;
    t.tone1_sample    = 8'(t1);
    t.tone2_sample    = 8'(t2);
    t.noise_sample    = 8'(nz);
    t.direct_a_sample = 8'(a);
    t.direct_b_sample = 8'(b);
    return t;
  endfunction

  // random samples, leaning on the extremes now and then
  function automatic ssmbc_pkg::mix_in_t random_tick();
    logic [39:0] bits;
    for (int i = 0; i < 5; i++) begin
      case ($urandom_range(0, 9))
        0:       bits[i*8 +: 8] = 8'h80;
        1:       bits[i*8 +: 8] = 8'h7F;
        default: bits[i*8 +: 8] = 8'($urandom());
      endcase
    end
    return ssmbc_pkg::mix_in_t'(bits);
  endfunction

  // writes all four registers, pipeline must be empty
  task automatic program_mixer(logic [15:0] mix, logic [15:0] direct, logic [15:0] master,
                               logic [15:0] bias);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= ssmbc_pkg::REG_MIX_CTRL;
    cfg_wdata_i <= mix;
    @(posedge clk_i);
    cfg_idx_i   <= ssmbc_pkg::REG_DIRECT_CTRL;
    cfg_wdata_i <= direct;
    @(posedge clk_i);
    cfg_idx_i   <= ssmbc_pkg::REG_MASTER_EN;
    cfg_wdata_i <= master;
    @(posedge clk_i);
    cfg_idx_i   <= ssmbc_pkg::REG_BIAS_LEVEL;
    cfg_wdata_i <= bias;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    mix_ctrl    = mix;
    direct_ctrl = direct;
    master_en   = master[0];
    bias_lvl    = bias[9:0];
    settings_used++;
  endtask

  task automatic program_random(int pick);
    logic [15:0] bias;
    logic [15:0] master;
    case ($urandom_range(0, 3))
      0:       bias = 16'h0000;
      1:       bias = 16'hFFFF;
      2:       bias = 16'h0200;
      default: bias = 16'($urandom());
    endcase
    master = {15'($urandom()), ($urandom_range(0, 7) != 0)};
    case (pick)
      0:       program_mixer(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      1:       program_mixer(16'hFFFF, 16'($urandom()), 16'h0001, 16'h0000);
      default: program_mixer(16'($urandom()), 16'($urandom()), master, bias);
    endcase
  endtask

  task automatic send_tick(ssmbc_pkg::mix_in_t t);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    do @(posedge clk_i); while (!in_ready_o);
    pending_mix.push_back(mix_tick(t));
    beats_sent++;
  endtask

  task automatic drain_mixer();
    in_valid_i <= 1'b0;
    while (pending_mix.size() != 0) @(posedge clk_i);
    repeat (DRAIN_TAIL) @(posedge clk_i);
  endtask

  // registers at their reset values: master off, zero bias
  task automatic test_reset_state();
    send_tick(make_tick(127, 127, 127, 127, 127));
    send_tick(make_tick(-128, -128, -128, -128, -128));
    send_tick(random_tick());
    drain_mixer();
  endtask

  task automatic test_directed_mix();
    // everything on at full volume, centered bias, clamps at both ends
    program_mixer(16'hFFFF, 16'h330E, 16'h0001, 16'h0200);
    send_tick(make_tick(127, 127, 127, 127, 127));
    send_tick(make_tick(-128, -128, -128, -128, -128));
    send_tick(make_tick(0, 0, 0, 0, 0));
    send_tick(make_tick(1, 2, 3, -1, 1));
    drain_mixer();
    // every shift code, odd negatives to catch truncation toward zero
    for (int code = 0; code < 4; code++) begin
      program_mixer(16'hBB53, 16'h3300 | 16'(code), 16'h0001, 16'h0200);
      send_tick(make_tick(-5, -3, -1, -3, -1));
      send_tick(make_tick(100, -7, 13, 127, -127));
      drain_mixer();
    end
    // master off with the prohibited code: only the bias passes, flag stays low
    program_mixer(16'hFFFF, 16'hFFFF, 16'hFFFE, 16'hFFFF);
    send_tick(make_tick(127, -128, 127, -128, 127));
    drain_mixer();
    program_mixer(16'hFFFF, 16'hFFFF, 16'h0000, 16'h012C);
    send_tick(random_tick());
    drain_mixer();
  endtask

  task automatic test_random_idle(int snd_pct, int rcv_pct, int n_settings, int n_beats);
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    for (int s = 0; s < n_settings; s++) begin
      program_random(s);
      repeat (n_beats) send_tick(random_tick());
      drain_mixer();
    end
  endtask

  // long receiver stall while the sender keeps offering beats
  task automatic test_output_backpressure();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    program_random(2);
    hold_asked++;
    repeat (40) send_tick(random_tick());
    drain_mixer();
  endtask

  // receiver: ready pattern, long hold on request, and result checking
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_mix.size() == 0) begin
          errors++;
          if (errors <= 10) $display("output beat with nothing pending: %h", out_data_o);
        end else begin
          want = pending_mix.pop_front();
          beats_checked++;
          if (out_data_o.left_sample !== want.left_sample ||
              out_data_o.right_sample !== want.right_sample ||
              out_data_o.bad_volume !== want.bad_volume) begin
            errors++;
            if (errors <= 10)
              $display("mismatch beat %0d: left exp %0d got %0d, right exp %0d got %0d, %s%0b got %0b",
                       beats_checked, want.left_sample, out_data_o.left_sample,
                       want.right_sample, out_data_o.right_sample,
                       "bad_volume exp ", want.bad_volume, out_data_o.bad_volume);
          end
        end
      end
      if (hold_served != hold_asked) begin
        hold_served <= hold_asked;
        hold_left   <= HOLD_LEN;
        out_ready_i <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left   <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("stereo_sound_mixer_bias_clamp_unit_tb: errors");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_directed_mix();
    test_random_idle(18, 61, 6, 60);
    test_random_idle(61, 18, 6, 60);
    test_random_idle(0, 0, 6, 55);
    test_output_backpressure();
    $display("%0d input beats sent, %0d results checked, %0d register settings",
             beats_sent, beats_checked, settings_used);
    $display("idle mixes on both sides, no idle, and one long output stall were exercised");
    if (errors == 0) begin
      $display("stereo_sound_mixer_bias_clamp_unit_tb: clean");
    end else begin
      $display("stereo_sound_mixer_bias_clamp_unit_tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
rtl/ssmbc_pkg.sv
rtl/stereo_sound_mixer_bias_clamp_unit.sv
tb/stereo_sound_mixer_bias_clamp_unit_tb.sv
